>>> src/hjb_pkg.sv
// Shared types and constants of the hash join build/probe engine.
package hjb_pkg;

    localparam int BUCKETS_DEF      = 1024;
    localparam int BUCKET_DEPTH_DEF = 4;
    localparam int KEY_W            = 32;
    localparam int HANDLE_W         = 32;
    localparam int ENTRY_W          = KEY_W + HANDLE_W;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_MATCH    = 2'd2,
        ST_NOMATCH  = 2'd3
    } t_res;

    typedef enum logic {
        CMD_BUILD = 1'b0,
        CMD_PROBE = 1'b1
    } t_op;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic mod_start;
        logic bkt_load;
        logic fill_load;
        logic insert;
        logic scan;
        logic clr;
        logic out_load;
        t_res code;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic is_probe;
        logic full;
        logic hit;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

>>> src/hjb_ram.sv
// Generic simple dual-port RAM with registered read data.
module hjb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/hjb_mod.sv
// Bucket index unit: key modulo the bucket count, radix-16 for general counts.
module hjb_mod #(
    parameter int BUCKETS = hjb_pkg::BUCKETS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hjb_pkg::KEY_W-1:0]   i_key,
    output logic                        o_done,
    output logic [$clog2(BUCKETS)-1:0]  o_rem
);

    localparam int BW = $clog2(BUCKETS);
    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

    generate
        if (IS_POW2) begin : g_pow2
            logic          r_done;
            logic [BW-1:0] r_rem;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
                if (i_start) begin
                    r_rem <= i_key[BW-1:0];
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end else begin : g_radix16
            localparam int TW = BW + 4;
            localparam int STEPS = hjb_pkg::KEY_W / 4;
            localparam int CW = $clog2(STEPS);

            logic                      r_busy;
            logic                      r_done;
            logic [CW-1:0]             r_cnt;
            logic [hjb_pkg::KEY_W-1:0] r_sh;
            logic [BW-1:0]             r_rem;
            logic [TW-1:0]             n_t;
            logic [TW-1:0]             n_sub;
            logic [BW-1:0]             n_rem;

            // shift in one nibble, take off the largest multiple that fits
            always_comb begin
                n_t   = {r_rem, r_sh[hjb_pkg::KEY_W-1 -: 4]};
                n_sub = '0;
                for (int k = 1; k < 16; k++) begin
                    if (n_t >= TW'(k * BUCKETS)) begin
                        n_sub = TW'(k * BUCKETS);
                    end
                end
                n_rem = BW'(n_t - n_sub);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (i_start) begin
                    r_busy <= 1'b1;
                    r_done <= 1'b0;
                    r_cnt  <= '0;
                end else if (r_busy) begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(STEPS - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_done <= 1'b0;
                end

                if (i_start) begin
                    r_sh  <= i_key;
                    r_rem <= '0;
                end else if (r_busy) begin
                    r_sh  <= r_sh << 4;
                    r_rem <= n_rem;
                end
            end

            assign o_done = r_done;
            assign o_rem  = r_rem;
        end
    endgenerate

endmodule

>>> src/hjb_dp.sv
// Datapath: input/output registers, bucket fill and entry memories, scan logic.
module hjb_dp #(
    parameter int BUCKETS      = hjb_pkg::BUCKETS_DEF,
    parameter int BUCKET_DEPTH = hjb_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hjb_pkg::t_cmd                  i_cmd_dp,
    output hjb_pkg::t_sts                  o_sts,
    input  logic                           i_in_cmd,
    input  logic [hjb_pkg::KEY_W-1:0]      i_in_key,
    input  logic [hjb_pkg::HANDLE_W-1:0]   i_in_handle,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [1:0]                     o_out_status,
    output logic [hjb_pkg::KEY_W-1:0]      o_out_key,
    output logic [hjb_pkg::HANDLE_W-1:0]   o_out_left,
    output logic [hjb_pkg::HANDLE_W-1:0]   o_out_right
);

    localparam int BW = $clog2(BUCKETS);
    localparam int FW = $clog2(BUCKET_DEPTH + 1);
    localparam int EN = BUCKETS * BUCKET_DEPTH;
    localparam int EW = $clog2(EN);
    localparam int KW = hjb_pkg::KEY_W;
    localparam int HW = hjb_pkg::HANDLE_W;

    logic                  r_op;
    logic [KW-1:0]         r_key;
    logic [HW-1:0]         r_handle;
    logic [BW-1:0]         r_bucket;
    logic [EW-1:0]         r_base;
    logic [FW-1:0]         r_fill;
    logic [FW-1:0]         r_idx;
    logic                  r_pend;
    logic [HW-1:0]         r_left;
    logic [BW-1:0]         r_clr_cnt;
    logic                  r_out_valid;
    hjb_pkg::t_res         r_out_status;
    logic [KW-1:0]         r_out_key;
    logic [HW-1:0]         r_out_left;
    logic [HW-1:0]         r_out_right;

    logic                  w_mod_done;
    logic [BW-1:0]         w_rem;
    logic                  w_fill_we;
    logic [BW-1:0]         w_fill_waddr;
    logic [FW-1:0]         w_fill_wdata;
    logic [FW-1:0]         w_fill_rdata;
    logic [EW-1:0]         w_ent_waddr;
    logic [EW-1:0]         w_ent_raddr;
    logic [hjb_pkg::ENTRY_W-1:0] w_ent_rdata;
    logic                  w_hit;
    logic                  w_more;

    hjb_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd_dp.mod_start),
        .i_key   (i_in_key),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    // clearing pass and inserts share the fill memory write port
    assign w_fill_we    = i_cmd_dp.clr | i_cmd_dp.insert;
    assign w_fill_waddr = i_cmd_dp.clr ? r_clr_cnt : r_bucket;
    assign w_fill_wdata = i_cmd_dp.clr ? '0 : r_fill + 1'b1;

    hjb_ram #(
        .WIDTH (FW),
        .DEPTH (BUCKETS)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (w_fill_we),
        .i_waddr (w_fill_waddr),
        .i_wdata (w_fill_wdata),
        .i_raddr (r_bucket),
        .o_rdata (w_fill_rdata)
    );

    assign w_ent_waddr = r_base + EW'(r_fill);
    assign w_ent_raddr = r_base + EW'(r_idx);

    hjb_ram #(
        .WIDTH (hjb_pkg::ENTRY_W),
        .DEPTH (EN)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd_dp.insert),
        .i_waddr (w_ent_waddr),
        .i_wdata ({r_key, r_handle}),
        .i_raddr (w_ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    assign w_hit  = r_pend && (w_ent_rdata[hjb_pkg::ENTRY_W-1 -: KW] == r_key);
    assign w_more = r_idx < r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_dp.clr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd_dp.fill_load) begin
                r_pend <= 1'b0;
            end else if (i_cmd_dp.scan) begin
                r_pend <= w_more;
            end
            if (i_cmd_dp.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end

        if (i_cmd_dp.load) begin
            r_op     <= i_in_cmd;
            r_key    <= i_in_key;
            r_handle <= i_in_handle;
        end
        if (i_cmd_dp.bkt_load) begin
            r_bucket <= w_rem;
            r_base   <= EW'(w_rem) * EW'(BUCKET_DEPTH);
        end
        if (i_cmd_dp.fill_load) begin
            r_fill <= w_fill_rdata;
            r_idx  <= '0;
        end else if (i_cmd_dp.scan && w_more) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd_dp.scan && w_hit) begin
            r_left <= w_ent_rdata[HW-1:0];
        end
        if (i_cmd_dp.out_load) begin
            r_out_status <= i_cmd_dp.code;
            r_out_key    <= r_key;
            r_out_left   <= (i_cmd_dp.code == hjb_pkg::ST_MATCH) ? r_left : '0;
            r_out_right  <= (r_op == hjb_pkg::CMD_PROBE) ? r_handle : '0;
        end
    end

    assign o_sts.clr_last = r_clr_cnt == BW'(BUCKETS - 1);
    assign o_sts.mod_done = w_mod_done;
    assign o_sts.is_probe = r_op == hjb_pkg::CMD_PROBE;
    assign o_sts.full     = r_fill >= FW'(BUCKET_DEPTH);
    assign o_sts.hit      = w_hit;
    assign o_sts.scan_end = !r_pend && (r_idx == r_fill);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_key    = r_out_key;
    assign o_out_left   = r_out_left;
    assign o_out_right  = r_out_right;

endmodule

>>> src/hjb_ctrl.sv
// Controller: sequences clearing, bucket lookup, insert and probe scan.
module hjb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hjb_pkg::t_sts i_sts,
    output hjb_pkg::t_cmd o_cmd_dp
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_FRD,
        S_FLD,
        S_EXEC,
        S_SCAN,
        S_RESP
    } t_state;

    t_state        r_state;
    hjb_pkg::t_res r_code;

    always_comb begin
        o_cmd_dp      = '0;
        o_cmd_dp.code = r_code;
        case (r_state)
            S_CLEAR: o_cmd_dp.clr = 1'b1;
            S_IDLE: begin
                o_cmd_dp.load      = i_in_valid;
                o_cmd_dp.mod_start = i_in_valid;
            end
            S_MOD:  o_cmd_dp.bkt_load  = i_sts.mod_done;
            S_FLD:  o_cmd_dp.fill_load = 1'b1;
            S_EXEC: o_cmd_dp.insert    = !i_sts.is_probe && !i_sts.full;
            S_SCAN: o_cmd_dp.scan      = 1'b1;
            S_RESP: o_cmd_dp.out_load  = i_sts.out_free;
            default: o_cmd_dp = '0;
        endcase
    end

    assign o_in_ready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_code  <= hjb_pkg::ST_INSERTED;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_MOD;
                end
                S_MOD: begin
                    if (i_sts.mod_done) r_state <= S_FRD;
                end
                S_FRD: r_state <= S_FLD;
                S_FLD: r_state <= S_EXEC;
                S_EXEC: begin
                    if (i_sts.is_probe) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_code  <= i_sts.full ? hjb_pkg::ST_FULL : hjb_pkg::ST_INSERTED;
                        r_state <= S_RESP;
                    end
                end
                S_SCAN: begin
                    // stop at the oldest equal key
                    if (i_sts.hit) begin
                        r_code  <= hjb_pkg::ST_MATCH;
                        r_state <= S_RESP;
                    end else if (i_sts.scan_end) begin
                        r_code  <= hjb_pkg::ST_NOMATCH;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_dp.out_load |-> i_sts.out_free)
        else $error("result loaded over an untaken transfer");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_dp.insert |-> !i_sts.full && !i_sts.is_probe)
        else $error("insert into a full bucket or on probe");

    a_scan_probe_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_dp.scan |-> i_sts.is_probe)
        else $error("bucket scan on a build item");

    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_dp.clr |-> !o_in_ready && !o_cmd_dp.load)
        else $error("input transfer during clearing pass");

endmodule

>>> src/hash_join_build_probe.sv
// Top level of the hash join build/probe engine.
//
// Input channel (i_valid/o_ready): i_cmd selects build (insert i_key and
// i_row_handle into bucket i_key mod BUCKETS) or probe (find the oldest
// stored row with an equal key). Output channel (o_valid/i_ready): one
// result per item with o_status, o_key_res, o_left_handle, o_right_handle.
// Items are handled one at a time. Each item computes its bucket index
// and reads the bucket fill count; a build then inserts the entry unless
// the bucket is full, and a probe scans the bucket entries from the
// oldest, one entry read per cycle from the entry memory, stopping at the
// first match or after the last entry. Power-of-two BUCKETS take the low
// key bits as the bucket index; other bucket counts use the radix-16
// remainder unit. After reset the bucket fill memory is cleared, one
// bucket per cycle; o_ready stays low during that pass.
// A stalled receiver holds the result in the output register; the next
// item is still taken and processed, and waits before its result is
// loaded until the register is free.
module hash_join_build_probe #(
    parameter int BUCKETS      = hjb_pkg::BUCKETS_DEF,
    parameter int BUCKET_DEPTH = hjb_pkg::BUCKET_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic [hjb_pkg::KEY_W-1:0]     i_key,
    input  logic [hjb_pkg::HANDLE_W-1:0]  i_row_handle,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [hjb_pkg::KEY_W-1:0]     o_key_res,
    output logic [hjb_pkg::HANDLE_W-1:0]  o_left_handle,
    output logic [hjb_pkg::HANDLE_W-1:0]  o_right_handle
);

    hjb_pkg::t_cmd w_cmd;
    hjb_pkg::t_sts w_sts;

    hjb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd_dp   (w_cmd)
    );

    hjb_dp #(
        .BUCKETS      (BUCKETS),
        .BUCKET_DEPTH (BUCKET_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_dp     (w_cmd),
        .o_sts        (w_sts),
        .i_in_cmd     (i_cmd),
        .i_in_key     (i_key),
        .i_in_handle  (i_row_handle),
        .i_out_ready  (i_ready),
        .o_out_valid  (o_valid),
        .o_out_status (o_status),
        .o_out_key    (o_key_res),
        .o_out_left   (o_left_handle),
        .o_out_right  (o_right_handle)
    );

endmodule
